>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions with a reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge.
`define FESG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge.
`define FESG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fesg_pkg.sv
// ----------------------------------------------------------------------------
// fesg_pkg
// Widths, stream layout and shared types of the filled ellipse span generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fesg_pkg;

    localparam int COORD_BITS   = 12;
    localparam int MAX_DIAMETER = 28;
    localparam int SIZE_W       = 5;
    localparam int COLOR_W      = 32;
    localparam int OUT_COORD_W  = COORD_BITS + 1;
    localparam int RW_W         = 5;
    localparam int RH_W         = 4;

    // Walk position widths: column offset and row offset.
    localparam int POS_W  = SIZE_W;
    localparam int HALF_W = SIZE_W - 1;
    // Small signed offsets applied to the center.
    localparam int DELTA_W = POS_W + 2;

    // Shared multiply-accumulate unit.
    localparam int SQ_W   = 2 * SIZE_W;
    localparam int OP_W   = 12;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 4;

    // Input item layout, lowest bit first.
    localparam int IN_CX_LSB     = 0;
    localparam int IN_CY_LSB     = IN_CX_LSB + COORD_BITS;
    localparam int IN_BW_LSB     = IN_CY_LSB + COORD_BITS;
    localparam int IN_BH_LSB     = IN_BW_LSB + SIZE_W;
    localparam int IN_COL_LSB    = IN_BH_LSB + SIZE_W;
    localparam int IN_FIELDS_W   = IN_COL_LSB + COLOR_W;
    localparam int IN_TDATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output item layout, lowest bit first.
    localparam int OUT_W_LSB     = 2 * OUT_COORD_W;
    localparam int OUT_FIELDS_W  = 2 * OUT_COORD_W + RW_W + RH_W + COLOR_W;
    localparam int OUT_TDATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef struct packed {
        logic en;   // update the accumulator
        logic clr;  // start from zero instead of the accumulator
        logic neg;  // subtract the product
        logic sh2;  // scale the product by four
    } t_mac_ctl;

    typedef struct packed {
        logic signed [OUT_COORD_W-1:0] x;
        logic signed [OUT_COORD_W-1:0] y;
        logic [RW_W-1:0]               w;
        logic [RH_W-1:0]               h;
    } t_rect;

endpackage

>>> rtl/fesg_mac.sv
// ----------------------------------------------------------------------------
// fesg_mac
// Shared multiplier with a signed accumulator for the ellipse decision terms.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fesg_mac (
    input  logic                                 i_clk,
    input  fesg_pkg::t_mac_ctl                   i_ctl,
    input  logic [fesg_pkg::OP_W-1:0]            i_op_a,
    input  logic [fesg_pkg::OP_W-1:0]            i_op_b,
    output logic [fesg_pkg::PROD_W-1:0]          o_prod,
    output logic signed [fesg_pkg::ACC_W-1:0]    o_sum
);
    import fesg_pkg::*;

    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] term;
    logic signed [ACC_W-1:0] base;

    assign o_prod = i_op_a * i_op_b;

    always_comb begin
        term = i_ctl.sh2 ? $signed(ACC_W'({o_prod, 2'b00})) : $signed(ACC_W'(o_prod));
        base = i_ctl.clr ? '0 : r_acc;
        o_sum = i_ctl.neg ? (base - term) : (base + term);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= o_sum;
        end
    end

endmodule

>>> rtl/filled_ellipse_span_generator.sv
// ----------------------------------------------------------------------------
// filled_ellipse_span_generator
// Midpoint ellipse fill: turns one ellipse request into a run of rectangles.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Signals                       Contents
//  s (req)   in   i_s_tvalid/o_s_tready/tdata   center, bounding size, color
//  m (rect)  out  o_m_tvalid/i_m_tready/tdata   one fill rectangle per item
//                 o_m_tlast                     set on the last rectangle
//
//  Sequence: setup squares the box width and height; each column step of
//  region one runs its decision terms and offers its rectangles until a
//  test ends that region; each row of region two does the same, and a flush
//  closes; one shared multiplier evaluates each decision term in turn.
//  Reset: synchronous, active low; idles the sequencer, empties both registers.
//  Stalls: a rectangle waits while the hold and output registers are full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module filled_ellipse_span_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request item, low bits first: center_x, center_y, box_width,
    // box_height, fill_color, zero fill.
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [fesg_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // Rectangle item, low bits first: rect_x, rect_y, rect_width,
    // rect_height, rect_color, zero fill. last_rect travels as o_m_tlast.
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [fesg_pkg::OUT_TDATA_W-1:0]  o_m_tdata,
    output logic                              o_m_tlast
);
    import fesg_pkg::*;

    // Sequencer states. Region one steps the column; region two steps the
    // row. Each decision takes a few multiply-accumulate passes.
    localparam logic [4:0] ST_IDLE    = 5'd0;
    localparam logic [4:0] ST_SQW     = 5'd1;   // W*W
    localparam logic [4:0] ST_SQH     = 5'd2;   // H*H
    localparam logic [4:0] ST_R1_TX   = 5'd3;   // acc = H2*x
    localparam logic [4:0] ST_R1_TY   = 5'd4;   // acc - W2*y < 0 ?
    localparam logic [4:0] ST_R1_XX   = 5'd5;   // sq = x*x
    localparam logic [4:0] ST_R1_HX   = 5'd6;   // acc = 4*H2*sq
    localparam logic [4:0] ST_R1_YY   = 5'd7;   // sq = (2y-1)^2
    localparam logic [4:0] ST_R1_WY   = 5'd8;   // acc += W2*sq
    localparam logic [4:0] ST_R1_DEC  = 5'd9;   // acc - W2*H2 >= 0 ?
    localparam logic [4:0] ST_R1_EMIT = 5'd10;
    localparam logic [4:0] ST_R2_STEP = 5'd11;
    localparam logic [4:0] ST_R2_XX   = 5'd12;  // sq = (2x+1)^2
    localparam logic [4:0] ST_R2_HX   = 5'd13;  // acc = H2*sq
    localparam logic [4:0] ST_R2_YY   = 5'd14;  // sq = y*y
    localparam logic [4:0] ST_R2_WY   = 5'd15;  // acc += 4*W2*sq
    localparam logic [4:0] ST_R2_DEC  = 5'd16;  // acc - W2*H2 <= 0 ?
    localparam logic [4:0] ST_R2_EMIT = 5'd17;
    localparam logic [4:0] ST_FLUSH   = 5'd18;

    localparam logic [1:0]              K_LAST     = 2'd3;
    localparam logic [1:0]              K_SECOND   = 2'd1;
    localparam logic [SIZE_W-1:0]       SIZE_MAX   = SIZE_W'(MAX_DIAMETER);
    localparam logic [SIZE_W-1:0]       HEIGHT_MIN = SIZE_W'(2);
    localparam logic [POS_W-1:0]        X_ONE      = POS_W'(1);
    localparam logic signed [DELTA_W-1:0] D_ONE    = DELTA_W'(1);
    localparam logic [RW_W-1:0]         RW_ONE     = RW_W'(1);
    localparam logic [RH_W-1:0]         RH_ONE     = RH_W'(1);

    // Control registers.
    logic [4:0] r_state, n_state;
    logic [1:0] r_k, n_k;
    logic       r_pend_v, n_pend_v;
    logic       r_out_v, n_out_v;

    // Payload registers.
    logic signed [COORD_BITS-1:0] r_xc, n_xc, r_yc, n_yc;
    logic [COLOR_W-1:0]           r_color, n_color;
    logic [SIZE_W-1:0]            r_w, n_w, r_h, n_h;
    logic [SQ_W-1:0]              r_w2, n_w2, r_h2, n_h2;
    logic [OP_W-1:0]              r_sq, n_sq;
    logic [POS_W-1:0]             r_x, n_x, r_xp, n_xp;
    logic [HALF_W-1:0]            r_y, n_y, r_yp, n_yp;
    t_rect                        r_pend, n_pend;
    t_rect                        r_out, n_out;
    logic [COLOR_W-1:0]           r_out_color, n_out_color;
    logic                         r_out_last, n_out_last;

    // Request fields.
    logic [SIZE_W-1:0] in_w, in_h, sat_w, sat_h;

    // Shared arithmetic unit.
    t_mac_ctl                mac_ctl;
    logic [OP_W-1:0]         op_a, op_b;
    logic [PROD_W-1:0]       prod;
    logic signed [ACC_W-1:0] mac_sum;

    // Rectangle under construction.
    logic                        em_cond, em_push, em_go;
    logic                        is_emit, out_free, can_push;
    logic signed [DELTA_W-1:0]   xs, xps, ys, yps, dx, dy;
    logic [POS_W:0]              x_dbl_m1, x_odd, xp_odd;
    logic [POS_W-1:0]            y_odd;
    t_rect                       em_rect;

    assign in_w  = i_s_tdata[IN_BW_LSB +: SIZE_W];
    assign in_h  = i_s_tdata[IN_BH_LSB +: SIZE_W];
    assign sat_w = (in_w > SIZE_MAX) ? SIZE_MAX : in_w;
    assign sat_h = (in_h > SIZE_MAX) ? SIZE_MAX : in_h;

    // Odd factors of the half-pixel terms: 2x-1, 2x+1, 2xp+1 and 2y-1.
    assign x_dbl_m1 = {r_x, 1'b0} - (POS_W + 1)'(1);
    assign x_odd    = {r_x, 1'b1};
    assign xp_odd   = {r_xp, 1'b1};
    assign y_odd    = {r_y - HALF_W'(1), 1'b1};

    // Operand selection for the shared multiplier.
    always_comb begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        unique case (r_state)
            ST_SQW: begin
                op_a = OP_W'(r_w);
                op_b = OP_W'(r_w);
            end
            ST_SQH: begin
                op_a = OP_W'(r_h);
                op_b = OP_W'(r_h);
            end
            ST_R1_TX: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                op_a = OP_W'(r_h2);
                op_b = OP_W'(r_x);
            end
            ST_R1_TY: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.neg = 1'b1;
                op_a = OP_W'(r_w2);
                op_b = OP_W'(r_y);
            end
            ST_R1_XX: begin
                op_a = OP_W'(r_x);
                op_b = OP_W'(r_x);
            end
            ST_R1_HX: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                mac_ctl.sh2 = 1'b1;
                op_a = OP_W'(r_h2);
                op_b = r_sq;
            end
            ST_R1_YY: begin
                op_a = OP_W'(y_odd);
                op_b = OP_W'(y_odd);
            end
            ST_R1_WY: begin
                mac_ctl.en = 1'b1;
                op_a = OP_W'(r_w2);
                op_b = r_sq;
            end
            ST_R1_DEC, ST_R2_DEC: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.neg = 1'b1;
                op_a = OP_W'(r_w2);
                op_b = OP_W'(r_h2);
            end
            ST_R2_XX: begin
                op_a = OP_W'(x_odd);
                op_b = OP_W'(x_odd);
            end
            ST_R2_HX: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.clr = 1'b1;
                op_a = OP_W'(r_h2);
                op_b = r_sq;
            end
            ST_R2_YY: begin
                op_a = OP_W'(r_y);
                op_b = OP_W'(r_y);
            end
            ST_R2_WY: begin
                mac_ctl.en  = 1'b1;
                mac_ctl.sh2 = 1'b1;
                op_a = OP_W'(r_w2);
                op_b = r_sq;
            end
            default: begin
            end
        endcase
    end

    fesg_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_prod (prod),
        .o_sum  (mac_sum)
    );

    // Rectangle geometry. Each walk step offers up to four rectangles,
    // selected by r_k; a rectangle whose condition fails is skipped.
    assign xs  = $signed(DELTA_W'(r_x));
    assign xps = $signed(DELTA_W'(r_xp));
    assign ys  = $signed(DELTA_W'(r_y));
    assign yps = $signed(DELTA_W'(r_yp));

    always_comb begin
        em_cond   = 1'b0;
        dx        = '0;
        dy        = '0;
        em_rect.w = '0;
        em_rect.h = '0;
        if (r_state == ST_R1_EMIT) begin
            if (!r_k[1]) begin
                // Single pixels above and below the center column when the
                // first column step already drops the row.
                em_cond   = (r_x == X_ONE) && (r_y != r_yp);
                dy        = r_k[0] ? (D_ONE - yps) : (yps - D_ONE);
                em_rect.w = RW_ONE;
                em_rect.h = RH_ONE;
            end else begin
                em_cond   = (r_y != r_yp);
                dx        = D_ONE - xs;
                dy        = r_k[0] ? yps : -yps;
                em_rect.w = x_dbl_m1[RW_W-1:0];
                em_rect.h = RH_ONE;
            end
        end else begin
            if (!r_k[1]) begin
                // Band of rows finished by a column step.
                em_cond   = (r_x != r_xp);
                dx        = -xps;
                dy        = r_k[0] ? (ys + D_ONE) : -yps;
                em_rect.w = xp_odd[RW_W-1:0];
                em_rect.h = RH_W'(r_yp - r_y);
            end else begin
                // Closing pair once the walk reaches the center row.
                em_cond   = (r_y == '0);
                dx        = -xps;
                dy        = r_k[0] ? '0 : -yps;
                em_rect.w = x_odd[RW_W-1:0];
                em_rect.h = r_k[0] ? RH_W'(r_yp + HALF_W'(1)) : RH_W'(r_yp);
            end
        end
        em_rect.x = OUT_COORD_W'(r_xc) + OUT_COORD_W'(dx);
        em_rect.y = OUT_COORD_W'(r_yc) + OUT_COORD_W'(dy);
    end

    // A new rectangle goes into the hold register; the one held there moves
    // to the output register. Holding one back lets the final rectangle of
    // a request carry tlast without looking ahead.
    assign is_emit  = (r_state == ST_R1_EMIT) || (r_state == ST_R2_EMIT);
    assign out_free = !r_out_v || i_m_tready;
    assign can_push = !r_pend_v || out_free;
    assign em_push  = is_emit && em_cond && can_push;
    assign em_go    = !em_cond || can_push;

    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_pend_v    = r_pend_v;
        n_out_v     = r_out_v && !i_m_tready;
        n_xc        = r_xc;
        n_yc        = r_yc;
        n_color     = r_color;
        n_w         = r_w;
        n_h         = r_h;
        n_w2        = r_w2;
        n_h2        = r_h2;
        n_sq        = r_sq;
        n_x         = r_x;
        n_y         = r_y;
        n_xp        = r_xp;
        n_yp        = r_yp;
        n_pend      = r_pend;
        n_out       = r_out;
        n_out_color = r_out_color;
        n_out_last  = r_out_last;

        if (em_push) begin
            if (r_pend_v) begin
                n_out       = r_pend;
                n_out_color = r_color;
                n_out_last  = 1'b0;
                n_out_v     = 1'b1;
            end
            n_pend   = em_rect;
            n_pend_v = 1'b1;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_xc    = $signed(i_s_tdata[IN_CX_LSB +: COORD_BITS]);
                    n_yc    = $signed(i_s_tdata[IN_CY_LSB +: COORD_BITS]);
                    n_color = i_s_tdata[IN_COL_LSB +: COLOR_W];
                    n_w     = sat_w;
                    n_h     = sat_h;
                    // A flat request produces no rectangle at all.
                    n_state = (sat_h < HEIGHT_MIN) ? ST_FLUSH : ST_SQW;
                end
            end
            ST_SQW: begin
                n_w2    = prod[SQ_W-1:0];
                n_state = ST_SQH;
            end
            ST_SQH: begin
                n_h2    = prod[SQ_W-1:0];
                n_x     = '0;
                n_y     = r_h[SIZE_W-1:1];
                n_yp    = r_h[SIZE_W-1:1];
                n_state = ST_R1_TX;
            end
            ST_R1_TX: begin
                n_state = ST_R1_TY;
            end
            ST_R1_TY: begin
                if (mac_sum[ACC_W-1]) begin
                    n_x     = r_x + POS_W'(1);
                    n_state = ST_R1_XX;
                end else begin
                    n_xp    = r_x;
                    n_yp    = r_y;
                    n_state = ST_R2_STEP;
                end
            end
            ST_R1_XX: begin
                n_sq    = prod[OP_W-1:0];
                n_state = ST_R1_HX;
            end
            ST_R1_HX: begin
                n_state = ST_R1_YY;
            end
            ST_R1_YY: begin
                n_sq    = prod[OP_W-1:0];
                n_state = ST_R1_WY;
            end
            ST_R1_WY: begin
                n_state = ST_R1_DEC;
            end
            ST_R1_DEC: begin
                if (!mac_sum[ACC_W-1]) begin
                    n_y = r_y - HALF_W'(1);
                end
                n_k     = '0;
                n_state = ST_R1_EMIT;
            end
            ST_R1_EMIT: begin
                if (em_go) begin
                    if (r_k == K_LAST) begin
                        n_yp    = r_y;
                        n_k     = '0;
                        n_state = ST_R1_TX;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            ST_R2_STEP: begin
                if (r_y != '0) begin
                    n_y     = r_y - HALF_W'(1);
                    n_state = ST_R2_XX;
                end else begin
                    n_state = ST_FLUSH;
                end
            end
            ST_R2_XX: begin
                n_sq    = prod[OP_W-1:0];
                n_state = ST_R2_HX;
            end
            ST_R2_HX: begin
                n_state = ST_R2_YY;
            end
            ST_R2_YY: begin
                n_sq    = prod[OP_W-1:0];
                n_state = ST_R2_WY;
            end
            ST_R2_WY: begin
                n_state = ST_R2_DEC;
            end
            ST_R2_DEC: begin
                if (mac_sum[ACC_W-1] || (mac_sum == '0)) begin
                    n_x = r_x + POS_W'(1);
                end
                n_k     = '0;
                n_state = ST_R2_EMIT;
            end
            ST_R2_EMIT: begin
                if (em_go) begin
                    // The closing pair starts from the band just written.
                    if ((r_k == K_SECOND) && (r_x != r_xp)) begin
                        n_xp = r_x;
                        n_yp = r_y;
                    end
                    if (r_k == K_LAST) begin
                        n_k     = '0;
                        n_state = ST_R2_STEP;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out       = r_pend;
                    n_out_color = r_color;
                    n_out_last  = 1'b1;
                    n_out_v     = 1'b1;
                    n_pend_v    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_k      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_k      <= n_k;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xc        <= n_xc;
        r_yc        <= n_yc;
        r_color     <= n_color;
        r_w         <= n_w;
        r_h         <= n_h;
        r_w2        <= n_w2;
        r_h2        <= n_h2;
        r_sq        <= n_sq;
        r_x         <= n_x;
        r_y         <= n_y;
        r_xp        <= n_xp;
        r_yp        <= n_yp;
        r_pend      <= n_pend;
        r_out       <= n_out;
        r_out_color <= n_out_color;
        r_out_last  <= n_out_last;
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = OUT_TDATA_W'({r_out_color, r_out.h, r_out.w, r_out.y, r_out.x});

endmodule

>>> rtl/fesg_checker.sv
// ----------------------------------------------------------------------------
// fesg_checker
// Port-level assertions for the filled ellipse span generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fesg_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [fesg_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import fesg_pkg::*;

    // Reset empties the output register.
    `FESG_ASSERT_NEXT(a_rst_empties, i_clk, 1'b1, !i_rst_n, !o_m_tvalid, "output valid after reset")

    // A waiting item stays offered and unchanged.
    `FESG_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid, "item dropped while stalled")
    `FESG_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata), "item changed while stalled")

    // One request at a time: the walk starts right after acceptance.
    `FESG_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready, "ready right after a request")

    // Every span is centered on the ellipse column, so its width is odd.
    `FESG_ASSERT_SAME(a_odd_width, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[OUT_W_LSB], "even rectangle width")

endmodule

bind filled_ellipse_span_generator fesg_checker u_fesg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
